@@ rtl/core/iidl_pkg.sv @@
// Shared types and codes for the indexed insert/delete list.
// No dependencies; imported by every module of the block.
`default_nettype none

package iidl_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 8;
  localparam int OP_W         = 3;
  localparam int COUNT_OUT_W  = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ     = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_POS  = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

  localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    logic ins;    // open a slot at the target index
    logic del;    // close the slot at the target index
    logic load;   // copy entries into the read lane
    logic shift;  // move the read lane one cell toward the head
  } cell_ctrl_t;

  // One result item
  typedef struct packed {
    logic signed [VALUE_W-1:0]   read_value;
    logic                        hit;
    logic                        accepted;
    logic [COUNT_OUT_W-1:0]      entry_count;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/iidl_cell.sv @@
// One list cell: a stored entry plus one stage of the read lane.
// Depends on iidl_pkg; instantiated once per list position by the top level.
`default_nettype none

module iidl_cell
  import iidl_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic [IDX_W-1:0]   at,
  input  wire logic [VALUE_W-1:0] new_value,
  input  wire logic [VALUE_W-1:0] left_entry,
  input  wire logic [VALUE_W-1:0] right_entry,
  input  wire logic [VALUE_W-1:0] right_lane,
  output logic      [VALUE_W-1:0] entry,
  output logic      [VALUE_W-1:0] lane
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  // Entry: insert shifts up from the left, delete pulls down from the right
  always_ff @(posedge clk) begin
    priority if (ctrl.ins && (MY_IDX == at)) begin
      entry <= new_value;
    end else if (ctrl.ins && (MY_IDX > at)) begin
      entry <= left_entry;
    end else if (ctrl.del && (MY_IDX >= at)) begin
      entry <= right_entry;
    end else begin
      entry <= entry;
    end
  end

  // Read lane: snapshot, then walk toward cell 0
  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      lane <= entry;
    end else if (ctrl.shift) begin
      lane <= right_lane;
    end else begin
      lane <= lane;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/iidl_outq.sv @@
// Two-entry result queue: output register plus skid register.
// Depends on iidl_pkg; instantiated by the top level.
`default_nettype none

module iidl_outq
  import iidl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t push_data,
  input  wire logic out_stall,
  output logic      out_valid,
  output res_t      out_data,
  output logic      skid_full
);

  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign pop       = out_valid && !out_stall;
  assign skid_full = skid_valid;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (!out_valid) begin
      out_valid  <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data  <= skid_valid ? skid_data : push_data;
      skid_data <= push_data;
    end else if (!out_valid) begin
      out_data  <= push_data;
    end else if (push && !skid_valid) begin
      skid_data <= push_data;
    end
  end

`ifndef SYNTHESIS
  // A push never finds both registers held
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !(out_valid && skid_valid && !pop))
    else $error("result queue overflow");
  // Skid holds data only behind a held output
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid valid without output valid");
  // A stalled output keeps its item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

@@ rtl/core/indexed_insert_delete_list.sv @@
// Indexed insert/delete list: a bounded ordered list of signed 32-bit values.
// Input channel (in_valid/in_stall) carries op, position, item_value; the
// output channel (out_valid/out_stall) returns read_value, hit, accepted and
// entry_count, exactly one result item per input item, in order.
// Storage is a row of CAPACITY cells; insert and delete shift every cell in
// parallel in the accept cycle, and they and every missed or ignored op push
// their result into the output queue in that cycle and leave the input free.
// A read that hits snapshots the row into the read lane and walks it toward
// cell 0, one cell per cycle; the result is pushed when the walk counter hits
// zero, and no new item is taken while the lane walks.
// Results go through a two-entry output queue; an item is still accepted
// while one result waits stalled, and in_stall rises once both are held.
// Reset (rst, synchronous) empties the list and the queue; cell contents are
// left as they are and never read before being written.
// Depends on iidl_pkg, iidl_cell and iidl_outq.
`default_nettype none

module indexed_insert_delete_list
  import iidl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [OP_W-1:0]           op,
  input  wire logic signed [POS_W-1:0]   position,
  input  wire logic signed [VALUE_W-1:0] item_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [VALUE_W-1:0]      read_value,
  output logic                           hit,
  output logic                           accepted,
  output logic [COUNT_OUT_W-1:0]         entry_count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic             st;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] rd_cnt;

  logic             in_accept;
  logic             skid_full;
  logic             pos_neg;
  logic [CMP_W-1:0] pos_u;
  logic [CMP_W-1:0] cnt_x;
  logic             full;
  logic             in_range;
  logic [CMP_W-1:0] at_x;
  logic             do_ins;
  logic             do_del;
  logic             start_read;
  logic             read_done;
  logic             push;
  res_t             push_data;
  res_t             out_data;
  cell_ctrl_t       ctrl;
  logic [CNT_W-1:0] count_after;

  logic [VALUE_W-1:0] entry_q [CAPACITY];
  logic [VALUE_W-1:0] lane_q  [CAPACITY];

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (st != ST_IDLE) || skid_full;

  // Operand decode
  assign pos_neg  = position[POS_W-1];
  assign pos_u    = CMP_W'(position[POS_W-2:0]);
  assign cnt_x    = CMP_W'(count);
  assign full     = (count == FULL_COUNT);
  assign in_range = !pos_neg && (pos_u < cnt_x);

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    start_read = 1'b0;
    at_x       = '0;
    unique case (op)
      OP_READ: begin
        start_read = in_range;
      end
      OP_INS_HEAD: begin
        do_ins = !full;
      end
      OP_INS_TAIL: begin
        at_x   = cnt_x;
        do_ins = !full;
      end
      OP_INS_POS: begin
        at_x   = pos_neg ? '0 : pos_u;
        do_ins = !full && (at_x <= cnt_x);
      end
      OP_DELETE: begin
        at_x   = pos_u;
        do_del = in_range;
      end
      default: begin
      end
    endcase
  end

  // Cell commands
  assign ctrl.ins   = in_accept && do_ins;
  assign ctrl.del   = in_accept && do_del;
  assign ctrl.load  = in_accept && start_read;
  assign ctrl.shift = (st == ST_READ);

  assign read_done = (st == ST_READ) && (rd_cnt == '0);

  always_comb begin
    priority if (ctrl.ins) begin
      count_after = count + 1'b1;
    end else if (ctrl.del) begin
      count_after = count - 1'b1;
    end else begin
      count_after = count;
    end
  end

  // Result to the queue
  assign push = (in_accept && !start_read) || read_done;

  always_comb begin
    if (read_done) begin
      push_data.read_value = lane_q[0];
      push_data.hit        = 1'b1;
      push_data.accepted   = 1'b1;
    end else begin
      push_data.read_value = MISS_VALUE;
      push_data.hit        = 1'b0;
      push_data.accepted   = do_ins || do_del;
    end
    push_data.entry_count = COUNT_OUT_W'(count_after);
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      count <= '0;
    end else begin
      count <= count_after;
      if (ctrl.load) begin
        st <= ST_READ;
      end else if (read_done) begin
        st <= ST_IDLE;
      end
    end
  end

  // Lane walk counter
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rd_cnt <= IDX_W'(pos_u);
    end else if (ctrl.shift) begin
      rd_cnt <= rd_cnt - 1'b1;
    end
  end

  // Row of cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VALUE_W-1:0] left_e;
    logic [VALUE_W-1:0] right_e;
    logic [VALUE_W-1:0] right_l;

    if (k == 0) begin : g_head
      assign left_e = item_value;
    end else begin : g_mid
      assign left_e = entry_q[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right_e = entry_q[k];
      assign right_l = lane_q[k];
    end else begin : g_body
      assign right_e = entry_q[k+1];
      assign right_l = lane_q[k+1];
    end

    iidl_cell #(
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .at          (IDX_W'(at_x)),
      .new_value   (item_value),
      .left_entry  (left_e),
      .right_entry (right_e),
      .right_lane  (right_l),
      .entry       (entry_q[k]),
      .lane        (lane_q[k])
    );
  end

  iidl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .skid_full (skid_full)
  );

  assign read_value  = out_data.read_value;
  assign hit         = out_data.hit;
  assign accepted    = out_data.accepted;
  assign entry_count = out_data.entry_count;

`ifndef SYNTHESIS
  // Entry count is frozen while the read lane walks
  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    (st == ST_READ) |=> $stable(count))
    else $error("count changed during read");
  // Count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("count above capacity");
  // Lane walk ends when its counter reaches zero
  a_read_end: assert property (@(posedge clk) disable iff (rst)
    read_done |=> (st == ST_IDLE))
    else $error("read did not finish");
  // A hit result is always an accepted one
  a_hit_acc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> accepted)
    else $error("hit without accepted");
`endif

endmodule

`default_nettype wire

@@ tb/list_checker.sv @@
// Checker for the indexed insert/delete list: watches both channels, keeps a
// shadow copy of the list, predicts each result item and compares it.
// Depends on iidl_pkg for widths, operation codes and the result layout.
`timescale 1ns / 100ps

module list_checker
  import iidl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [OP_W-1:0]           op,
  input  logic signed [POS_W-1:0]   position,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [VALUE_W-1:0] read_value,
  input  logic                      hit,
  input  logic                      accepted,
  input  logic [COUNT_OUT_W-1:0]    entry_count,
  output int                        failures,
  output int                        outstanding,
  output int                        list_len,
  output int                        checked,
  output int                        read_hits,
  output int                        full_refusals
);

  // Shadow of the list contents, head at index 0
  logic [VALUE_W-1:0] shadow_list [$];
  // Results predicted but not yet seen on the output channel
  res_t               awaited_results [$];

  int n_fail    = 0;
  int n_checked = 0;
  int n_hits    = 0;
  int n_full    = 0;

  // Open a slot at 'at' and store the value; refused when full or past the end
  function automatic bit place_entry(int at, logic [VALUE_W-1:0] value);
    if (shadow_list.size() >= DEF_CAPACITY || at > shadow_list.size())
      return 1'b0;
    shadow_list.insert(at, value);
    return 1'b1;
  endfunction

  // Apply one operation to the shadow list and return the result it gives
  function automatic res_t apply_list_op(logic [OP_W-1:0] code,
                                         logic signed [POS_W-1:0] at,
                                         logic [VALUE_W-1:0] value);
    res_t r;
    int   idx;
    r.read_value = MISS_VALUE;
    r.hit        = 1'b0;
    r.accepted   = 1'b0;
    idx          = int'(at);
    case (code)
      OP_READ: begin
        if (idx >= 0 && idx < shadow_list.size()) begin
          r.read_value = shadow_list[idx];
          r.hit        = 1'b1;
          r.accepted   = 1'b1;
        end
      end
      OP_INS_HEAD: r.accepted = place_entry(0, value);
      OP_INS_TAIL: r.accepted = place_entry(shadow_list.size(), value);
      // negative position goes to the head
      OP_INS_POS:  r.accepted = place_entry((idx < 0) ? 0 : idx, value);
      OP_DELETE: begin
        if (idx >= 0 && idx < shadow_list.size()) begin
          shadow_list.delete(idx);
          r.accepted = 1'b1;
        end
      end
      default: ;  // spare codes change nothing
    endcase
    r.entry_count = COUNT_OUT_W'(shadow_list.size());
    return r;
  endfunction

  // Compare outgoing items first, then predict the incoming one
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      shadow_list.delete();
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result item: read_value %h hit %b accepted %b count %0d",
                   $time, read_value, hit, accepted, entry_count);
          n_fail++;
        end else begin
          want = awaited_results.pop_front();
          n_checked++;
          if (read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, want.read_value, read_value);
            n_fail++;
          end
          if (hit !== want.hit) begin
            $display("%0t: hit expected %b actual %b", $time, want.hit, hit);
            n_fail++;
          end
          if (accepted !== want.accepted) begin
            $display("%0t: accepted expected %b actual %b",
                     $time, want.accepted, accepted);
            n_fail++;
          end
          if (entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.entry_count, entry_count);
            n_fail++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if ((op == OP_INS_HEAD || op == OP_INS_TAIL || op == OP_INS_POS) &&
            shadow_list.size() == DEF_CAPACITY)
          n_full++;
        want = apply_list_op(op, position, item_value);
        if (want.hit)
          n_hits++;
        awaited_results.push_back(want);
      end
    end
    failures      <= n_fail;
    outstanding   <= awaited_results.size();
    list_len      <= shadow_list.size();
    checked       <= n_checked;
    read_hits     <= n_hits;
    full_refusals <= n_full;
  end

endmodule

@@ tb/testbench.sv @@
// Top of the indexed insert/delete list testbench: clock, reset, directed and
// random item streams with idle bursts, and the verdict.
// Depends on iidl_pkg, the block itself and list_checker.
`timescale 1ns / 100ps

module testbench;
  import iidl_pkg::*;

  localparam int              RANDOM_ITEMS   = 1300;
  localparam int              CYCLE_LIMIT    = 1_000_000;
  localparam int              QUIET_TAIL     = 150;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int              SEG_FILL       = 0;
  localparam int              SEG_DRAIN      = 1;
  localparam int              SEG_MIXED      = 2;

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           op         = OP_READ;
  logic signed [POS_W-1:0]   position   = '0;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic signed [VALUE_W-1:0] read_value;
  logic                      hit;
  logic                      accepted;
  logic [COUNT_OUT_W-1:0]    entry_count;

  int failures, outstanding, list_len, checked, read_hits, full_refusals;
  int items_sent = 0;
  int cycles     = 0;
  bit idle_en    = 1'b1;

  indexed_insert_delete_list i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .position    (position),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .hit         (hit),
    .accepted    (accepted),
    .entry_count (entry_count)
  );

  list_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .position      (position),
    .item_value    (item_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_value    (read_value),
    .hit           (hit),
    .accepted      (accepted),
    .entry_count   (entry_count),
    .failures      (failures),
    .outstanding   (outstanding),
    .list_len      (list_len),
    .checked       (checked),
    .read_hits     (read_hits),
    .full_refusals (full_refusals)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("indexed_insert_delete_list verification failed");
    $finish;
  end

  // Receiver: random stall bursts while idling is enabled
  initial begin
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Present one item, maybe after an idle burst, and hold it until taken
  task automatic offer_item(logic [OP_W-1:0] code, logic signed [POS_W-1:0] at,
                            logic signed [VALUE_W-1:0] value);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= code;
    position   <= at;
    item_value <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Position biased toward the live range, with misses on both sides
  function automatic logic signed [POS_W-1:0] pick_position(int len);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7)
      return POS_W'($urandom_range(0, (len > 0) ? len - 1 : 0));
    else if (r == 7)
      return POS_W'(len);
    else if (r == 8)
      return POS_W'(-int'($urandom_range(1, 64)));
    else
      return POS_W'(int'($urandom_range(0, 128)) - 64);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int seg_kind, seg_len, seg_no, r;
    int t_read, t_head, t_tail, t_pos, t_del;
    logic [OP_W-1:0] code;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, every op, ends and misses
    offer_item(OP_READ,     0,  32'h1234_5678);
    offer_item(OP_DELETE,   0,  '0);
    offer_item(OP_INS_POS,  1,  32'h1111_1111);   // past the end of an empty list
    offer_item(OP_INS_HEAD, 0,  32'h7FFF_FFFF);
    offer_item(OP_INS_TAIL, 0,  32'h8000_0000);
    offer_item(OP_INS_POS,  -64, 32'hFFFF_FFFF);  // negative goes to head
    offer_item(OP_INS_POS,  3,  32'h0000_0000);   // equal to count: tail
    offer_item(OP_INS_POS,  1,  32'h5A5A_5A5A);
    offer_item(OP_INS_POS,  7,  32'hA5A5_A5A5);   // past the end
    offer_item(OP_READ,     -1, '0);
    offer_item(OP_READ,     0,  '0);
    offer_item(OP_READ,     4,  '0);
    offer_item(OP_READ,     5,  '0);
    offer_item(OP_READ,     64, '0);
    offer_item(OP_READ,     -64, '0);
    offer_item(3'(OP_SPARE_FIRST),     63, $urandom);
    offer_item(3'(OP_SPARE_FIRST + 1), -1, $urandom);
    offer_item(OP_SPARE_LAST,          64, $urandom);
    offer_item(OP_DELETE,   -1, '0);
    offer_item(OP_DELETE,   5,  '0);
    offer_item(OP_DELETE,   4,  '0);               // tail
    offer_item(OP_DELETE,   0,  '0);               // head
    offer_item(OP_DELETE,   1,  '0);               // middle
    offer_item(OP_READ,     1,  '0);

    // Random: segments that fill, drain or churn the list
    seg_no = 0;
    while (items_sent < RANDOM_ITEMS + 24) begin
      seg_kind = seg_no % 3;
      seg_len  = $urandom_range(60, 150);
      idle_en  = (items_sent < RANDOM_ITEMS + 24 - QUIET_TAIL) &&
                 ($urandom_range(0, 3) != 0);
      case (seg_kind)
        SEG_FILL:  begin t_read = 20; t_head = 40; t_tail = 60; t_pos = 85; t_del = 95; end
        SEG_DRAIN: begin t_read = 20; t_head = 25; t_tail = 30; t_pos = 40; t_del = 95; end
        default:   begin t_read = 30; t_head = 42; t_tail = 54; t_pos = 70; t_del = 95; end
      endcase
      repeat (seg_len) begin
        if (items_sent < RANDOM_ITEMS + 24) begin
          if (items_sent >= RANDOM_ITEMS + 24 - QUIET_TAIL)
            idle_en = 1'b0;
          r = $urandom_range(0, 99);
          if (r < t_read)      code = OP_READ;
          else if (r < t_head) code = OP_INS_HEAD;
          else if (r < t_tail) code = OP_INS_TAIL;
          else if (r < t_pos)  code = OP_INS_POS;
          else if (r < t_del)  code = OP_DELETE;
          else                 code = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
          offer_item(code, pick_position(list_len), pick_value());
        end
      end
      seg_no++;
    end

    // Drain
    in_valid <= 1'b0;
    idle_en  = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (2 * DEF_CAPACITY + 8) @(posedge clk);

    $display("Sent %0d items, checked %0d results: %0d read hits, %0d inserts refused when full",
             items_sent, checked, read_hits, full_refusals);
    if (failures == 0 && outstanding == 0)
      $display("indexed_insert_delete_list verification clean");
    else
      $display("indexed_insert_delete_list verification failed");
    $finish;
  end

endmodule
